>>> rtl/dd_pkg.sv
// shared types and constants for the deadlock detection core
// no dependencies; used by scoped name from dd_alu, deadlock_detection_core and tb_top
package dd_pkg;

    // item function codes
    localparam logic [1:0] FUNC_LOAD_AVAIL = 2'd0;
    localparam logic [1:0] FUNC_LOAD_ROW   = 2'd1;
    localparam logic [1:0] FUNC_RUN        = 2'd2;

    // configuration register indexes
    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

    // fixed field widths
    localparam int PID_W  = 4;
    localparam int RID_W  = 3;
    localparam int PORT_AMT_W = 16;
    localparam int PCNT_W = 5;
    localparam int RCNT_W = 4;
    localparam int CFG_W  = 5;

    // hard ceiling on processes a run walks
    localparam int PROC_LIMIT = 16;

    localparam logic [PCNT_W-1:0] PCOUNT_RESET = 5'd16;
    localparam logic [RCNT_W-1:0] RCOUNT_RESET = 4'd8;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

endpackage

>>> rtl/dd_alu.sv
// shared add/subtract unit: request check and saturating available update
// depends on dd_pkg for the operation code
module dd_alu #(
    parameter int AW = 16
) (
    input  dd_pkg::alu_op_t op,
    input  logic [AW-1:0]   a,
    input  logic [AW-1:0]   b,
    output logic [AW-1:0]   sum,
    output logic            carry
);

    logic [AW:0] total;
    logic [AW-1:0] b_eff;
    logic          cin;

    always_comb
    begin
        b_eff = (op == dd_pkg::ALU_SUB) ? ~b : b;
        cin   = (op == dd_pkg::ALU_SUB);
        total = {1'b0, a} + {1'b0, b_eff} + {{AW{1'b0}}, cin};
        sum   = total[AW-1:0];
        // sub: carry set means a >= b; add: carry set means overflow
        carry = total[AW];
    end

endmodule

>>> rtl/dd_matrix_mem.sv
// allocation and request matrices, one row per process, packed side by side
// single port, registered read; no package dependency
module dd_matrix_mem #(
    parameter int AW     = 16,
    parameter int ADDR_W = 7
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic            rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [2*AW-1:0] wdata,
    output logic [2*AW-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [2*AW-1:0] mem [DEPTH];
    logic [2*AW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/deadlock_detection_core.sv
// deadlock detection core: load sequencer, detection sequencer, output register
// depends on dd_pkg, dd_alu and dd_matrix_mem
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | in        | in_valid / in_ready | func, process_index, resource_index,
//          |           |                     | held_amount, wanted_amount
//  out     | out       | out_valid/out_ready | finished_process, is_status, deadlock,
//          |           |                     | finished_total
//  cfg     | in        | cfg_we              | cfg_idx, cfg_wdata
//
// load beats are written as they are accepted and never hold in_ready low. a run beat
// holds in_ready low until its status beat is placed in the output register. each
// visited unfinished process is picked, then each resource is checked on the shared
// add/subtract unit (matrix read then compare); on success each resource is read again
// and saturating-added into available, and the id beat is placed. finished processes
// are skipped at their visit and every pass ends with an end-of-pass check. a run makes
// at most np+1 passes. reset clears the sequencer, finished count and output valid and
// sets the configured counts to their defaults; matrices and available vector come up
// undefined. a stalled output only holds the sequencer at its next emit step.
module deadlock_detection_core #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int AMOUNT_WIDTH  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config port
    input  logic                            cfg_we,
    input  logic                            cfg_idx,
    input  logic [dd_pkg::CFG_W-1:0]        cfg_wdata,
    // input beats
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic [dd_pkg::PID_W-1:0]        process_index,
    input  logic [dd_pkg::RID_W-1:0]        resource_index,
    input  logic [dd_pkg::PORT_AMT_W-1:0]   held_amount,
    input  logic [dd_pkg::PORT_AMT_W-1:0]   wanted_amount,
    // result beats
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dd_pkg::PID_W-1:0]        finished_process,
    output logic                            is_status,
    output logic                            deadlock,
    output logic [dd_pkg::PCNT_W-1:0]       finished_total
);

    localparam int AW  = AMOUNT_WIDTH;
    localparam int PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PL  = (MAX_PROCESSES < dd_pkg::PROC_LIMIT) ? MAX_PROCESSES
                                                               : dd_pkg::PROC_LIMIT;
    localparam int FIW = (PL > 1) ? $clog2(PL) : 1;
    localparam int PW  = dd_pkg::PCNT_W;
    localparam int RW  = dd_pkg::RCNT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PROC = 3'd1;   // pick next process of the pass
    localparam logic [2:0] S_CRD  = 3'd2;   // read request/allocation word
    localparam logic [2:0] S_CHK  = 3'd3;   // request vs available
    localparam logic [2:0] S_ARD  = 3'd4;   // read again for the add loop
    localparam logic [2:0] S_ADD  = 3'd5;   // saturating add into available
    localparam logic [2:0] S_EMIT = 3'd6;   // place finished id beat
    localparam logic [2:0] S_STAT = 3'd7;   // place status beat

    logic [2:0]     state_reg, state_next;
    logic [PW-1:0]  i_reg, i_next;          // process counter
    logic [RW-1:0]  j_reg, j_next;          // resource counter
    logic           progress_reg, progress_next;
    logic [PW-1:0]  cnt_reg, cnt_next;
    logic [PL-1:0]  flags_reg;
    logic           flags_clr, flag_set;

    logic [PW-1:0]  pcount_reg;
    logic [RW-1:0]  rcount_reg;
    logic [PW-1:0]  np;
    logic [RW-1:0]  nr;

    // available vector, small enough to live in flops
    logic [AW-1:0]  avail_reg [MAX_RESOURCES];
    logic           avail_we;
    logic [RIW-1:0] avail_widx;
    logic [AW-1:0]  avail_wdata;
    logic [AW-1:0]  avail_rd;

    // matrix memory
    logic                mem_we, mem_re;
    logic [PIW+RIW-1:0]  mem_addr;
    logic [2*AW-1:0]     mem_wdata, mem_q;
    logic [AW-1:0]       q_alloc, q_req;

    // shared arithmetic unit
    dd_pkg::alu_op_t alu_op;
    logic [AW-1:0]   alu_b, alu_sum;
    logic            alu_carry;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic [dd_pkg::PID_W-1:0] proc_reg;
    logic            status_reg, dead_reg;
    logic [PW-1:0]   total_reg;
    logic            out_free, out_load, out_status;

    logic            p_ok, r_ok, last_res;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= dd_pkg::PCOUNT_RESET;
            rcount_reg <= dd_pkg::RCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                dd_pkg::REG_PROCESS_COUNT:  pcount_reg <= cfg_wdata[PW-1:0];
                dd_pkg::REG_RESOURCE_COUNT: rcount_reg <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // counts in use, clamped to the store sizes
    assign np = (pcount_reg > PW'(PL)) ? PW'(PL) : pcount_reg;
    assign nr = (32'(rcount_reg) > MAX_RESOURCES) ? RW'(MAX_RESOURCES) : rcount_reg;

    // ---------------------------------------------------------------- datapath
    assign p_ok      = 32'(process_index) < MAX_PROCESSES;
    assign r_ok      = 32'(resource_index) < MAX_RESOURCES;
    assign avail_rd  = avail_reg[RIW'(j_reg)];
    assign q_alloc   = mem_q[2*AW-1:AW];
    assign q_req     = mem_q[AW-1:0];
    assign mem_wdata = {AW'(held_amount), AW'(wanted_amount)};
    assign mem_addr  = (state_reg == S_IDLE) ? {PIW'(process_index), RIW'(resource_index)}
                                             : {PIW'(i_reg), RIW'(j_reg)};
    assign last_res  = (j_reg == nr - RW'(1));
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    dd_matrix_mem #(
        .AW     (AW),
        .ADDR_W (PIW + RIW)
    ) u_mem (
        .clk   (clk),
        .wr_en (mem_we),
        .rd_en (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    dd_alu #(
        .AW (AW)
    ) u_alu (
        .op    (alu_op),
        .a     (avail_rd),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        progress_next = progress_reg;
        cnt_next      = cnt_reg;
        flags_clr     = 1'b0;
        flag_set      = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        avail_we      = 1'b0;
        avail_widx    = RIW'(j_reg);
        avail_wdata   = alu_carry ? {AW{1'b1}} : alu_sum;
        alu_op        = dd_pkg::ALU_SUB;
        alu_b         = q_req;
        out_load      = 1'b0;
        out_status    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        dd_pkg::FUNC_LOAD_AVAIL:
                        begin
                            avail_we    = r_ok;
                            avail_widx  = RIW'(resource_index);
                            avail_wdata = AW'(held_amount);
                        end
                        dd_pkg::FUNC_LOAD_ROW:
                        begin
                            mem_we = p_ok && r_ok;
                        end
                        dd_pkg::FUNC_RUN:
                        begin
                            flags_clr     = 1'b1;
                            cnt_next      = '0;
                            i_next        = '0;
                            progress_next = 1'b0;
                            state_next    = S_PROC;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROC:
            begin
                if (i_reg >= np)
                begin
                    // end of pass: go again only if something finished
                    if (progress_reg)
                    begin
                        i_next        = '0;
                        progress_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_STAT;
                    end
                end
                else if (flags_reg[FIW'(i_reg)])
                begin
                    i_next = i_reg + PW'(1);
                end
                else if (nr == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                mem_re     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // no carry out of available minus request: request too large
                if (!alu_carry)
                begin
                    i_next     = i_reg + PW'(1);
                    state_next = S_PROC;
                end
                else if (last_res)
                begin
                    j_next     = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    j_next     = j_reg + RW'(1);
                    state_next = S_CRD;
                end
            end
            S_ARD:
            begin
                mem_re     = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                alu_op   = dd_pkg::ALU_ADD;
                alu_b    = q_alloc;
                avail_we = 1'b1;
                if (last_res)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next     = j_reg + RW'(1);
                    state_next = S_ARD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    flag_set      = 1'b1;
                    cnt_next      = cnt_reg + PW'(1);
                    progress_next = 1'b1;
                    i_next        = i_reg + PW'(1);
                    state_next    = S_PROC;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_status = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            progress_reg  <= 1'b0;
            cnt_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            progress_reg  <= progress_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (flags_clr)
            begin
                flags_reg <= '0;
            end
            else if (flag_set)
            begin
                flags_reg[FIW'(i_reg)] <= 1'b1;
            end
        end
    end

    // available vector and output payload need no reset
    always_ff @(posedge clk)
    begin
        if (avail_we)
        begin
            avail_reg[avail_widx] <= avail_wdata;
        end
        if (out_load)
        begin
            proc_reg   <= out_status ? '0 : dd_pkg::PID_W'(i_reg);
            status_reg <= out_status;
            dead_reg   <= out_status && (cnt_reg != np);
            total_reg  <= out_status ? cnt_reg : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign finished_process = proc_reg;
    assign is_status        = status_reg;
    assign deadlock         = dead_reg;
    assign finished_total   = total_reg;

    // ---------------------------------------------------------------- checks
    // a process id beat is never placed twice in one run
    a_no_double_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |-> !flags_reg[FIW'(i_reg)])
        else $error("process finished twice in one run");

    // a compare only follows its matrix read
    a_chk_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> ($past(state_reg) == S_CRD))
        else $error("compare without matching matrix read");

    // finished count stays within the processes in use during a run
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg <= np))
        else $error("finished count exceeds processes in use");

    // status beat only goes out when the run ended after a pass with no progress
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STAT) |-> !progress_reg)
        else $error("status placed while a pass still made progress");

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for deadlock_detection_core: named tests, random idling
// depends on dd_pkg and the deadlock_detection_core rtl; predicts every result beat
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // widths and codes shared with the rtl
    localparam int         PID_W              = dd_pkg::PID_W;
    localparam int         RID_W              = dd_pkg::RID_W;
    localparam int         PORT_AMT_W         = dd_pkg::PORT_AMT_W;
    localparam int         PCNT_W             = dd_pkg::PCNT_W;
    localparam int         RCNT_W             = dd_pkg::RCNT_W;
    localparam int         CFG_W              = dd_pkg::CFG_W;
    localparam int         PROC_LIMIT         = dd_pkg::PROC_LIMIT;
    localparam logic [1:0] FUNC_LOAD_AVAIL    = dd_pkg::FUNC_LOAD_AVAIL;
    localparam logic [1:0] FUNC_LOAD_ROW      = dd_pkg::FUNC_LOAD_ROW;
    localparam logic [1:0] FUNC_RUN           = dd_pkg::FUNC_RUN;
    localparam logic       REG_PROCESS_COUNT  = dd_pkg::REG_PROCESS_COUNT;
    localparam logic       REG_RESOURCE_COUNT = dd_pkg::REG_RESOURCE_COUNT;
    localparam logic [PCNT_W-1:0] PCOUNT_RESET = dd_pkg::PCOUNT_RESET;
    localparam logic [RCNT_W-1:0] RCOUNT_RESET = dd_pkg::RCOUNT_RESET;

    localparam int CLK_PERIOD   = 10;
    localparam int N_PROC       = 16;
    localparam int N_RES        = 8;
    // even if every item were a worst-case full-size run under heavy stalls, the run time
    // stays far below this
    localparam int LIMIT_CYCLES = 20000000;
    // loads are written at the edge that accepts them, so a short settle covers any load still in flight
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 20;

    // func code the core ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // one result beat as the core presents it
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic              status;
        logic              dead;
        logic [PCNT_W-1:0] total;
    } result_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_idx = REG_PROCESS_COUNT;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            func = FUNC_LOAD_AVAIL;
    logic [PID_W-1:0]      process_index = '0;
    logic [RID_W-1:0]      resource_index = '0;
    logic [PORT_AMT_W-1:0] held_amount = '0;
    logic [PORT_AMT_W-1:0] wanted_amount = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PID_W-1:0]      finished_process;
    logic                  is_status;
    logic                  deadlock;
    logic [PCNT_W-1:0]     finished_total;

    deadlock_detection_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .process_index    (process_index),
        .resource_index   (resource_index),
        .held_amount      (held_amount),
        .wanted_amount    (wanted_amount),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .finished_process (finished_process),
        .is_status        (is_status),
        .deadlock         (deadlock),
        .finished_total   (finished_total)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // shadow copy of the core's stores and registers
    // ------------------------------------------------------------------
    logic [PORT_AMT_W-1:0] avail_units  [N_RES];
    logic [PORT_AMT_W-1:0] held_units   [N_PROC][N_RES];
    logic [PORT_AMT_W-1:0] wanted_units [N_PROC][N_RES];
    // which entries were ever loaded; a run must never read one that was not
    bit                    avail_loaded [N_RES];
    bit                    row_loaded   [N_PROC][N_RES];
    logic [PCNT_W-1:0]     pcount_reg = PCOUNT_RESET;
    logic [RCNT_W-1:0]     rcount_reg = RCOUNT_RESET;

    result_beat_t          expected_beats[$];
    result_beat_t          want_beat;

    int                    mismatches = 0;
    int                    items_sent = 0;
    int                    cycle_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;

    // counts above the store size are clamped
    function automatic int procs_active();
        return (pcount_reg > PROC_LIMIT) ? PROC_LIMIT : int'(pcount_reg);
    endfunction

    function automatic int res_active();
        return (rcount_reg > N_RES) ? N_RES : int'(rcount_reg);
    endfunction

    // detection: repeat passes until one finishes nothing, then the status beat
    function automatic void predict_run();
        bit                  done [N_PROC];
        int                  np;
        int                  nr;
        int                  total;
        bit                  progress;
        bit                  fits;
        logic [PORT_AMT_W:0] sum;
        result_beat_t        beat;
        np = procs_active();
        nr = res_active();
        total = 0;
        progress = 1'b1;
        foreach (done[i]) done[i] = 1'b0;
        while (progress)
        begin
            progress = 1'b0;
            for (int i = 0; i < np; i++)
            begin
                if (!done[i])
                begin
                    fits = 1'b1;
                    for (int j = 0; j < nr; j++)
                        if (wanted_units[i][j] > avail_units[j])
                            fits = 1'b0;
                    if (fits)
                    begin
                        // release the holdings, saturating at the top of the range
                        for (int j = 0; j < nr; j++)
                        begin
                            sum = {1'b0, avail_units[j]} + {1'b0, held_units[i][j]};
                            avail_units[j] = sum[PORT_AMT_W] ? '1 : sum[PORT_AMT_W-1:0];
                        end
                        done[i] = 1'b1;
                        total++;
                        beat = '{pid: PID_W'(i), status: 1'b0, dead: 1'b0, total: '0};
                        expected_beats.push_back(beat);
                        progress = 1'b1;
                    end
                end
            end
        end
        beat = '{pid: '0, status: 1'b1, dead: (total != np), total: PCNT_W'(total)};
        expected_beats.push_back(beat);
    endfunction

    // small amounts dominate so that runs form chains of releases
    function automatic logic [PORT_AMT_W-1:0] rand_amount();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return PORT_AMT_W'($urandom);
            default: return PORT_AMT_W'($urandom_range(0, 7));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input side: one beat per call, random gaps before valid rises
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] f, input logic [PID_W-1:0] p,
                             input logic [RID_W-1:0] r, input logic [PORT_AMT_W-1:0] h,
                             input logic [PORT_AMT_W-1:0] w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        func           <= f;
        process_index  <= p;
        resource_index <= r;
        held_amount    <= h;
        wanted_amount  <= w;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        // beat accepted at this edge: update the shadow state
        case (f)
            FUNC_LOAD_AVAIL:
            begin
                avail_units[r]  = h;
                avail_loaded[r] = 1'b1;
            end
            FUNC_LOAD_ROW:
            begin
                held_units[p][r]   = h;
                wanted_units[p][r] = w;
                row_loaded[p][r]   = 1'b1;
            end
            FUNC_RUN:
                predict_run();
            default:
                ;
        endcase
        if (f != FUNC_UNUSED)
            items_sent++;
    endtask

    // run beat with random content in the fields it does not use
    task automatic send_run();
        send_item(FUNC_RUN, PID_W'($urandom), RID_W'($urandom),
                  PORT_AMT_W'($urandom), PORT_AMT_W'($urandom));
    endtask

    // hold the sender off until every expected beat is back and loads have settled
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // both registers, only while the core is idle
    task automatic write_config(input logic [CFG_W-1:0] procs, input logic [CFG_W-1:0] res);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_PROCESS_COUNT;
        cfg_wdata <= procs;
        pcount_reg = procs;
        @(negedge clk);
        cfg_idx   <= REG_RESOURCE_COUNT;
        cfg_wdata <= res;
        rcount_reg = res[RCNT_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // load every entry a run at the present counts reads but that was never loaded
    task automatic fill_needed();
        for (int j = 0; j < res_active(); j++)
            if (!avail_loaded[j])
                send_item(FUNC_LOAD_AVAIL, PID_W'($urandom), RID_W'(j), rand_amount(),
                          PORT_AMT_W'($urandom));
        for (int i = 0; i < procs_active(); i++)
            for (int j = 0; j < res_active(); j++)
                if (!row_loaded[i][j])
                    send_item(FUNC_LOAD_ROW, PID_W'(i), RID_W'(j), rand_amount(),
                              rand_amount());
    endtask

    // mostly small sizes, sometimes zero, full or clamped counts
    task automatic pick_config();
        logic [CFG_W-1:0] procs;
        logic [RCNT_W-1:0] res;
        case ($urandom_range(0, 19))
            0:
            begin
                procs = '0;
                res   = RCNT_W'($urandom_range(0, 8));
            end
            1:
            begin
                procs = CFG_W'(N_PROC);
                res   = RCNT_W'(N_RES);
            end
            2:
            begin
                procs = CFG_W'($urandom_range(17, 31));
                res   = RCNT_W'($urandom_range(9, 15));
            end
            3:
            begin
                procs = CFG_W'($urandom_range(1, 6));
                res   = '0;
            end
            default:
            begin
                procs = CFG_W'($urandom_range(1, 5));
                res   = RCNT_W'($urandom_range(1, 4));
            end
        endcase
        // the top write-data bit is beyond the resource register and must be dropped
        write_config(procs, {1'($urandom_range(0, 1)), res});
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, then compare each beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: finished_process %0d is_status %0d",
                       finished_process, is_status);
                mismatches++;
            end
            else
            begin
                want_beat = expected_beats.pop_front();
                if (finished_process !== want_beat.pid)
                begin
                    $error("finished_process expected %0d got %0d", want_beat.pid,
                           finished_process);
                    mismatches++;
                end
                if (is_status !== want_beat.status)
                begin
                    $error("is_status expected %0d got %0d", want_beat.status, is_status);
                    mismatches++;
                end
                if (deadlock !== want_beat.dead)
                begin
                    $error("deadlock expected %0d got %0d", want_beat.dead, deadlock);
                    mismatches++;
                end
                if (finished_total !== want_beat.total)
                begin
                    $error("finished_total expected %0d got %0d", want_beat.total,
                           finished_total);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // one process releases, which lets another finish, while a third stays blocked
    task automatic test_chain_and_deadlock();
        write_config(5'd3, 5'd2);
        send_item(FUNC_LOAD_AVAIL, 4'd0, 3'd0, 16'd1, 16'd0);
        send_item(FUNC_LOAD_AVAIL, 4'd0, 3'd1, 16'd0, 16'hFFFF);
        send_item(FUNC_LOAD_ROW, 4'd0, 3'd0, 16'd2, 16'd2);
        send_item(FUNC_LOAD_ROW, 4'd0, 3'd1, 16'd0, 16'd0);
        send_item(FUNC_LOAD_ROW, 4'd1, 3'd0, 16'd0, 16'd5);
        send_item(FUNC_LOAD_ROW, 4'd1, 3'd1, 16'd0, 16'd1);
        send_item(FUNC_LOAD_ROW, 4'd2, 3'd0, 16'd1, 16'd1);
        send_item(FUNC_LOAD_ROW, 4'd2, 3'd1, 16'd3, 16'd0);
        // row outside the counts in use is kept but must not affect the run
        send_item(FUNC_LOAD_ROW, 4'd15, 3'd7, 16'hFFFF, 16'hFFFF);
        // unused func code with every field at its top value: no beat, no effect
        send_item(FUNC_UNUSED, 4'd15, 3'd7, 16'hFFFF, 16'hFFFF);
        send_run();
        wait_drained();
    endtask

    // release saturates available, and available carries over into the next run
    task automatic test_saturation();
        write_config(5'd1, 5'd1);
        send_item(FUNC_LOAD_AVAIL, 4'd0, 3'd0, 16'hFFF0, 16'd0);
        send_item(FUNC_LOAD_ROW, 4'd0, 3'd0, 16'hFFFF, 16'd0);
        send_run();
        send_item(FUNC_LOAD_ROW, 4'd0, 3'd0, 16'd0, 16'hFFFF);
        send_run();
        send_item(FUNC_LOAD_AVAIL, 4'd0, 3'd0, 16'd0, 16'd0);
        send_run();
    endtask

    // no processes in use, then no resources in use
    task automatic test_zero_counts();
        write_config(5'd0, 5'd5);
        send_run();
        write_config(5'd4, 5'd0);
        send_run();
    endtask

    // sessions of loads then a run; config changes between sessions
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int target, input logic [CFG_W-1:0] first_procs,
                                     input logic [CFG_W-1:0] first_res);
        int stop_at;
        int loads;
        int np;
        int nr;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + target;
        write_config(first_procs, first_res);
        while (items_sent < stop_at)
        begin
            np = procs_active();
            nr = res_active();
            loads = $urandom_range(2, 10);
            repeat (loads)
            begin
                case ($urandom_range(0, 19))
                    0:
                        send_item(FUNC_UNUSED, PID_W'($urandom), RID_W'($urandom),
                                  PORT_AMT_W'($urandom), PORT_AMT_W'($urandom));
                    1, 2:
                        send_item(FUNC_LOAD_AVAIL, PID_W'($urandom), RID_W'($urandom),
                                  rand_amount(), PORT_AMT_W'($urandom));
                    3, 4:
                        send_item(FUNC_LOAD_ROW, PID_W'($urandom), RID_W'($urandom),
                                  rand_amount(), rand_amount());
                    5, 6, 7:
                        send_item(FUNC_LOAD_AVAIL, PID_W'($urandom),
                                  RID_W'(nr > 0 ? $urandom_range(0, nr - 1) : $urandom),
                                  rand_amount(), PORT_AMT_W'($urandom));
                    default:
                        send_item(FUNC_LOAD_ROW,
                                  PID_W'(np > 0 ? $urandom_range(0, np - 1) : $urandom),
                                  RID_W'(nr > 0 ? $urandom_range(0, nr - 1) : $urandom),
                                  rand_amount(), rand_amount());
                endcase
            end
            fill_needed();
            send_run();
            // back-to-back runs see the available vector left by the first
            if ($urandom_range(0, 3) == 0)
                send_run();
            if ($urandom_range(0, 2) == 0)
                pick_config();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 69;
        test_chain_and_deadlock();
        test_saturation();
        test_zero_counts();

        test_random_phase(33, 69, 150, 5'd16, 5'd8);
        test_random_phase(69, 33, 150, 5'd31, 5'd31);
        test_random_phase(0, 0, 150, 5'd2, 5'd3);

        wait_drained();
        repeat (END_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
